### src/ire_pkg.sv
package ire_pkg;

  localparam int unsigned UnitW = 7;
  localparam int unsigned ByteW = 8;
  localparam int unsigned FrameW = 32;
  localparam int unsigned BitCntW = 6;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_LEADER_MARK = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LEADER_SPACE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAP = 2'd2;

  localparam logic [UnitW-1:0] LEADER_MARK_RST = 7'd16;
  localparam logic [UnitW-1:0] LEADER_SPACE_RST = 7'd8;
  localparam logic [UnitW-1:0] GAP_RST = 7'd71;

  localparam logic func_tick = 1'b0;
  localparam logic func_send = 1'b1;

  typedef struct packed {
    logic [UnitW-1:0] leader_mark_units;
    logic [UnitW-1:0] leader_space_units;
    logic [UnitW-1:0] gap_units;
  } cfg_t;

  typedef struct packed {
    logic rejected;
    logic busy_res;
    logic carrier_on;
  } result_t;

endpackage

### src/ire_cfg.sv
module ire_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ire_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ire_pkg::UnitW-1:0]   cfg_wdata_i,
  output ire_pkg::cfg_t               cfg_o
);

  ire_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_mark_units <= ire_pkg::LEADER_MARK_RST;
      cfg_q.leader_space_units <= ire_pkg::LEADER_SPACE_RST;
      cfg_q.gap_units <= ire_pkg::GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ire_pkg::CFG_LEADER_MARK: cfg_q.leader_mark_units <= cfg_wdata_i;
        ire_pkg::CFG_LEADER_SPACE: cfg_q.leader_space_units <= cfg_wdata_i;
        ire_pkg::CFG_GAP: cfg_q.gap_units <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/ire_seq.sv
module ire_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      func_i,
  input  logic [ire_pkg::ByteW-1:0] address_i,
  input  logic [ire_pkg::ByteW-1:0] command_i,
  input  ire_pkg::cfg_t             cfg_i,
  output ire_pkg::result_t          result_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LMARK  = 3'd1,
    PH_LSPACE = 3'd2,
    PH_BMARK  = 3'd3,
    PH_BSPACE = 3'd4,
    PH_STOP   = 3'd5,
    PH_GAP    = 3'd6
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [ire_pkg::UnitW-1:0]     unit_q, unit_d;
  logic [ire_pkg::FrameW-1:0]    frame_q, frame_d;
  logic [ire_pkg::BitCntW-1:0]   left_q, left_d;
  logic                          busy;
  logic                          done;
  logic [ire_pkg::UnitW-1:0]     unit_dec;
  logic [ire_pkg::BitCntW-1:0]   left_dec;
  ire_pkg::result_t              res;

  assign busy = phase_q inside {PH_LMARK, PH_LSPACE, PH_BMARK, PH_BSPACE, PH_STOP, PH_GAP};
  assign done = (unit_q <= ire_pkg::UnitW'(1));
  assign unit_dec = unit_q - ire_pkg::UnitW'(1);
  assign left_dec = left_q - ire_pkg::BitCntW'(1);

  always_comb begin
    phase_d = phase_q;
    unit_d = unit_q;
    frame_d = frame_q;
    left_d = left_q;
    res = '0;
    res.busy_res = busy;
    if (func_i == ire_pkg::func_send) begin
      res.busy_res = 1'b1;
      if (busy) begin
        res.rejected = 1'b1;
      end else begin
        frame_d = {~command_i, command_i, ~address_i, address_i};
        left_d = ire_pkg::BitCntW'(ire_pkg::FrameW);
        phase_d = PH_LMARK;
        unit_d = cfg_i.leader_mark_units;
      end
    end else begin
      case (phase_q)
        PH_LMARK: begin
          res.carrier_on = 1'b1;
          unit_d = done ? '0 : unit_dec;
          if (done) begin
            phase_d = PH_LSPACE;
            unit_d = cfg_i.leader_space_units;
          end
        end
        PH_LSPACE: begin
          unit_d = done ? '0 : unit_dec;
          if (done) begin
            phase_d = PH_BMARK;
            unit_d = ire_pkg::UnitW'(1);
          end
        end
        PH_BMARK: begin
          res.carrier_on = 1'b1;
          phase_d = PH_BSPACE;
          unit_d = frame_q[0] ? ire_pkg::UnitW'(3) : ire_pkg::UnitW'(1);
        end
        PH_BSPACE: begin
          unit_d = done ? '0 : unit_dec;
          if (done) begin
            frame_d = frame_q >> 1;
            left_d = left_dec;
            phase_d = (left_dec == '0) ? PH_STOP : PH_BMARK;
            unit_d = ire_pkg::UnitW'(1);
          end
        end
        PH_STOP: begin
          res.carrier_on = 1'b1;
          if (cfg_i.gap_units == '0) begin
            phase_d = PH_IDLE;
            unit_d = '0;
          end else begin
            phase_d = PH_GAP;
            unit_d = cfg_i.gap_units;
          end
        end
        PH_GAP: begin
          unit_d = done ? '0 : unit_dec;
          if (done) begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      unit_q <= '0;
      frame_q <= '0;
      left_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      unit_q <= unit_d;
      frame_q <= frame_d;
      left_q <= left_d;
    end
  end

  assign result_o = res;

endmodule

### src/ire_obuf.sv
module ire_obuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ire_pkg::result_t push_data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_ready_i,
  output ire_pkg::result_t data_o
);

  logic             main_valid_q;
  logic             skid_valid_q;
  ire_pkg::result_t main_q;
  ire_pkg::result_t skid_q;
  logic             pop;

  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o = main_q;
  assign pop = main_valid_q && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      main_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i && !main_valid_q) begin
      main_q <= push_data_i;
    end
    if (push_i && main_valid_q && !pop) begin
      skid_q <= push_data_i;
    end
  end

endmodule

### src/ir_frame_pulse_encoder.sv
// NEC-style infrared frame encoder. Send an item with tuser = 1 to start a frame of
// address, ~address, command, ~command (LSB first); every item with tuser = 0 is one
// 562.5us unit tick and returns the carrier enable for that unit. Every item returns
// exactly one result via a two-entry registered output buffer; a new item is accepted
// every cycle unless it is full. Leader and gap lengths go over the config port: the user
// must write them only while idle, as the block itself does not enforce this.
module ir_frame_pulse_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // address, command
  input  logic                          s_axis_tuser,  // func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // carrier_on, busy_res, rejected, 0s
  input  logic                          cfg_we_i,
  input  logic [ire_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ire_pkg::UnitW-1:0]     cfg_wdata_i
);

  ire_pkg::cfg_t    cfg;
  ire_pkg::result_t result;
  ire_pkg::result_t out_res;
  logic             accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  ire_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ire_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .func_i    (s_axis_tuser),
    .address_i (s_axis_tdata[7:0]),
    .command_i (s_axis_tdata[15:8]),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  ire_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.rejected, out_res.busy_res, out_res.carrier_on};

endmodule
